// File: hw/rtl/ipcv_pkg.sv
// Package for the IPv4 CIDR string validator.
// Character codes, field limits and the step struct shared by the modules.
// No dependencies.
package ipcv_pkg;

  localparam int unsigned MAX_CHARS_DEF = 20;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [9:0] OCTET_LIMIT   = 10'd255;
  localparam logic [9:0] PREFIX_LIMIT  = 10'd32;
  localparam logic [1:0] OCTET_DIGITS  = 2'd3;
  localparam logic [1:0] PREFIX_DIGITS = 2'd2;
  localparam logic [1:0] LAST_OCTET    = 2'd3;

  // one character handed from the input register to the parser
  typedef struct packed {
    logic       fire;
    logic [7:0] ch;
  } ipcv_step_t;

endpackage

// File: hw/rtl/ipcv_if.sv
// Handshake channels of the IPv4 CIDR string validator.
// ipcv_ch_if carries one character, ipcv_res_if one validity result. No dependencies.
interface ipcv_ch_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ipcv_res_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

// File: hw/rtl/ipv4_cidr_string_validator.sv
// IPv4 CIDR string validator: top level.
// Input register, ipcv_parse state update, output register. Depends on ipcv_pkg, ipcv_if.
//
// Usage:
//   in_chan  : one ASCII character per item (ch); 8'h00 ends the string.
//   out_chan : one item (valid_res) per ending NUL, 1 when the string had the
//              form a.b.c.d/p with octets <= 255 and prefix <= 32.
//   Characters past the first MAX_CHARS of a string are dropped silently.
//   Throughput: one character per cycle, sustained, including across strings, while out_chan takes its results.
//   Path: an accepted NUL is held in the input register, then the verdict
//   loads into the output register, from which out_chan offers it.
//   Reset (rst_n low, synchronous) clears the parser state and empties both
//   registers; the first character after reset starts a new string.
//   Stall: when out_chan is held off, characters keep flowing through the
//   parser until the next NUL reaches the input register; that NUL waits
//   there, and in_chan.ready drops, until the output register frees up.
module ipv4_cidr_string_validator import ipcv_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ipcv_ch_if.sink           in_chan,
  ipcv_res_if.source        out_chan
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_ch_r;
  logic       out_valid_r, out_valid_nxt;
  logic       out_res_r;

  logic       out_free;
  logic       s1_is_nul;
  logic       s1_fire;
  logic       in_fire;
  logic       ok;
  ipcv_step_t step;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign s1_is_nul = (s1_ch_r == CH_NUL);
  // only the NUL needs room in the output register
  assign s1_fire   = s1_valid_r && (!s1_is_nul || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire   = in_chan.valid && in_chan.ready;

  assign step.fire = s1_fire;
  assign step.ch   = s1_ch_r;

  ipcv_parse #(.MAX_CHARS(MAX_CHARS)) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ok    (ok)
  );

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = (s1_fire && s1_is_nul) ? 1'b1 :
                    (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r <= in_chan.ch;
    end
    if (s1_fire && s1_is_nul) begin
      out_res_r <= ok;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.valid_res = out_res_r;

endmodule

// File: hw/rtl/ipcv_parse.sv
// Per-character parser state of the IPv4 CIDR string validator.
// Updates the octet/prefix state on each step and flags validity at the NUL.
// Depends on ipcv_pkg.
module ipcv_parse import ipcv_pkg::*; #(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ipcv_step_t step,
  output logic       ok
);

  localparam int unsigned CW = $clog2(MAX_CHARS + 1);

  logic          in_prefix_r,      in_prefix_nxt;
  logic [1:0]    octet_pos_r,      octet_pos_nxt;
  logic [1:0]    digit_count_r,    digit_count_nxt;
  logic [9:0]    field_value_r,    field_value_nxt;
  logic          any_octet_over_r, any_octet_over_nxt;
  logic          error_seen_r,     error_seen_nxt;
  logic [CW-1:0] chars_taken_r,    chars_taken_nxt;

  logic       is_nul;
  logic       is_digit;
  logic [9:0] accum;

  assign is_nul   = (step.ch == CH_NUL);
  assign is_digit = (step.ch >= CH_ZERO) && (step.ch <= CH_NINE);
  // value*10 + digit; low nibble of an ASCII digit is its value
  assign accum    = (field_value_r << 3) + (field_value_r << 1) + 10'(step.ch[3:0]);

  assign ok = !error_seen_r && in_prefix_r && (digit_count_r != 2'd0) &&
              !any_octet_over_r && (field_value_r <= PREFIX_LIMIT);

  always_comb begin
    in_prefix_nxt      = in_prefix_r;
    octet_pos_nxt      = octet_pos_r;
    digit_count_nxt    = digit_count_r;
    field_value_nxt    = field_value_r;
    any_octet_over_nxt = any_octet_over_r;
    error_seen_nxt     = error_seen_r;
    chars_taken_nxt    = chars_taken_r;

    if (step.fire) begin
      if (is_nul) begin
        in_prefix_nxt      = 1'b0;
        octet_pos_nxt      = 2'd0;
        digit_count_nxt    = 2'd0;
        field_value_nxt    = 10'd0;
        any_octet_over_nxt = 1'b0;
        error_seen_nxt     = 1'b0;
        chars_taken_nxt    = '0;
      end else if (chars_taken_r < CW'(MAX_CHARS)) begin
        chars_taken_nxt = chars_taken_r + CW'(1);
        if (!error_seen_r) begin
          if (in_prefix_r) begin
            if (is_digit && (digit_count_r < PREFIX_DIGITS)) begin
              field_value_nxt = accum;
              digit_count_nxt = digit_count_r + 2'd1;
            end else begin
              error_seen_nxt = 1'b1;
            end
          end else if (is_digit) begin
            if (digit_count_r >= OCTET_DIGITS) begin
              error_seen_nxt = 1'b1;
            end else begin
              field_value_nxt = accum;
              digit_count_nxt = digit_count_r + 2'd1;
            end
          end else if (step.ch == CH_DOT) begin
            if ((digit_count_r == 2'd0) || (octet_pos_r >= LAST_OCTET)) begin
              error_seen_nxt = 1'b1;
            end else begin
              if (field_value_r > OCTET_LIMIT) any_octet_over_nxt = 1'b1;
              octet_pos_nxt   = octet_pos_r + 2'd1;
              digit_count_nxt = 2'd0;
              field_value_nxt = 10'd0;
            end
          end else if ((step.ch == CH_SLASH) && (octet_pos_r == LAST_OCTET)) begin
            if (digit_count_r == 2'd0) begin
              error_seen_nxt = 1'b1;
            end else begin
              if (field_value_r > OCTET_LIMIT) any_octet_over_nxt = 1'b1;
              in_prefix_nxt   = 1'b1;
              digit_count_nxt = 2'd0;
              field_value_nxt = 10'd0;
            end
          end else begin
            error_seen_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prefix_r      <= 1'b0;
      octet_pos_r      <= 2'd0;
      digit_count_r    <= 2'd0;
      field_value_r    <= 10'd0;
      any_octet_over_r <= 1'b0;
      error_seen_r     <= 1'b0;
      chars_taken_r    <= '0;
    end else begin
      in_prefix_r      <= in_prefix_nxt;
      octet_pos_r      <= octet_pos_nxt;
      digit_count_r    <= digit_count_nxt;
      field_value_r    <= field_value_nxt;
      any_octet_over_r <= any_octet_over_nxt;
      error_seen_r     <= error_seen_nxt;
      chars_taken_r    <= chars_taken_nxt;
    end
  end

  a_prefix_digits: assert property (@(posedge clk) disable iff (!rst_n)
    in_prefix_r |-> (digit_count_r <= PREFIX_DIGITS) && (octet_pos_r == LAST_OCTET))
    else $error("prefix state inconsistent");

  a_chars_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chars_taken_r <= CW'(MAX_CHARS))
    else $error("character count past limit");

  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step.fire && is_nul) |=> (chars_taken_r == '0) && !error_seen_r && !in_prefix_r &&
                              (digit_count_r == 2'd0))
    else $error("state not cleared after end of string");

  a_error_held: assert property (@(posedge clk) disable iff (!rst_n)
    (error_seen_r && !(step.fire && is_nul)) |=> error_seen_r)
    else $error("error dropped before end of string");

endmodule

// File: sim/tb_ipv4_cidr_string_validator.sv
// Testbench for ipv4_cidr_string_validator: sends address strings one character per item
// and checks every verdict against an in-bench tracker of the a.b.c.d/p parse.
// Depends on ipcv_pkg, ipcv_if and the RTL top level.
module tb_ipv4_cidr_string_validator;
  import ipcv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT      = 1000;
  localparam int SETTLE_CYCLES       = 8;
  localparam int RANDOM_CHARS_TARGET = 1250;
  localparam int PHASE_CHARS         = 300;
  localparam int MAX_REPORTS         = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ipcv_ch_if  in_chan ();
  ipcv_res_if out_chan ();

  ipv4_cidr_string_validator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // parse tracker state
  logic       pfx_mode;
  logic [1:0] octet_idx;
  logic [1:0] n_digits;
  logic [9:0] acc;
  logic       octet_over;
  logic       fmt_err;
  logic [4:0] n_taken;

  logic       verdicts_due[$];
  logic [7:0] text_buf[$];

  int chars_parsed    = 0;
  int bad_count       = 0;
  int max_src_gap     = 18;
  int max_snk_gap     = 18;
  int hold_off_cycles = 0;
  int idle_cycles     = 0;

  task automatic clear_tracker();
    pfx_mode   = 1'b0;
    octet_idx  = '0;
    n_digits   = '0;
    acc        = '0;
    octet_over = 1'b0;
    fmt_err    = 1'b0;
    n_taken    = '0;
  endtask

  // advance the tracker by one accepted character; a NUL queues the verdict
  task automatic track_char(input logic [7:0] c);
    logic       is_dig;
    logic [9:0] d;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d = {2'b00, c - CH_ZERO};
    if (c == CH_NUL) begin
      chars_parsed++;
      verdicts_due.push_back(!fmt_err && pfx_mode && (n_digits != 0) && !octet_over &&
                             (acc <= PREFIX_LIMIT));
      clear_tracker();
      return;
    end
    if (n_taken >= MAX_CHARS_DEF) return;
    n_taken++;
    chars_parsed++;
    if (fmt_err) return;
    if (pfx_mode) begin
      if (is_dig && (n_digits < PREFIX_DIGITS)) begin
        acc = 10'(acc * 10 + d);
        n_digits++;
      end else begin
        fmt_err = 1'b1;
      end
    end else if (is_dig) begin
      if (n_digits >= OCTET_DIGITS) begin
        fmt_err = 1'b1;
      end else begin
        acc = 10'(acc * 10 + d);
        n_digits++;
      end
    end else if (c == CH_DOT) begin
      if ((n_digits == 0) || (octet_idx >= LAST_OCTET)) begin
        fmt_err = 1'b1;
      end else begin
        if (acc > OCTET_LIMIT) octet_over = 1'b1;
        octet_idx++;
        n_digits = '0;
        acc = '0;
      end
    end else if ((c == CH_SLASH) && (octet_idx == LAST_OCTET)) begin
      if (n_digits == 0) begin
        fmt_err = 1'b1;
      end else begin
        if (acc > OCTET_LIMIT) octet_over = 1'b1;
        pfx_mode = 1'b1;
        n_digits = '0;
        acc = '0;
      end
    end else begin
      fmt_err = 1'b1;
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = $urandom_range(max_src_gap, 0);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    track_char(c);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s.getc(i));
  endtask

  task automatic send_text_buf();
    foreach (text_buf[i]) send_char(text_buf[i]);
    send_char(CH_NUL);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    append_text(s);
    send_text_buf();
  endtask

  // drop valid, then wait until every verdict is back
  task automatic finish_phase();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  function automatic string octet_text();
    case ($urandom_range(9, 0))
      7: return $sformatf("%0d", $urandom_range(999, 256));
      8: return $sformatf("%03d", $urandom_range(99, 0));
      9: return ($urandom_range(1, 0) != 0) ? "255" : "256";
      default: return $sformatf("%0d", $urandom_range(255, 0));
    endcase
  endfunction

  function automatic string prefix_text();
    case ($urandom_range(9, 0))
      7: return $sformatf("%0d", $urandom_range(99, 33));
      8: return $sformatf("%02d", $urandom_range(9, 0));
      9: return ($urandom_range(1, 0) != 0) ? "32" : "33";
      default: return $sformatf("%0d", $urandom_range(32, 0));
    endcase
  endfunction

  // well-formed address with random content, sometimes damaged
  task automatic build_address();
    int pos;
    text_buf.delete();
    for (int k = 0; k < 4; k++) begin
      append_text(octet_text());
      if (k < 3) text_buf.push_back(CH_DOT);
    end
    text_buf.push_back(CH_SLASH);
    append_text(prefix_text());
    pos = $urandom_range(text_buf.size() - 1, 0);
    case ($urandom_range(11, 0))
      6:  text_buf[pos] = 8'($urandom_range(255, 1));
      7:  text_buf.delete(pos);
      8:  text_buf.insert(pos, CH_DOT);
      9:  text_buf.insert(pos, CH_SLASH);
      10: text_buf.insert(pos, 8'(CH_ZERO + $urandom_range(9, 0)));
      11: repeat ($urandom_range(12, 1)) text_buf.push_back(8'($urandom_range(255, 1)));
      default: ;
    endcase
  endtask

  task automatic report_bad(input string msg);
    bad_count++;
    if (bad_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_verdict(input logic got);
    logic want;
    if (verdicts_due.size() == 0) begin
      report_bad($sformatf("valid_res %b arrived with no string pending", got));
      return;
    end
    want = verdicts_due.pop_front();
    if (got !== want) report_bad($sformatf("valid_res expected %b, actual %b", want, got));
  endtask

  task automatic test_well_formed();
    send_string("0.0.0.0/0");
    send_string("255.255.255.255/32");
    send_string("192.168.001.010/08");
    send_string("123.123.123.123/32");
    finish_phase();
  endtask

  task automatic test_field_limits();
    send_string("256.0.0.0/8");
    send_string("1.2.3.999/8");
    send_string("1.2.3.4/33");
    send_string("1234.1.1.1/2");
    send_string("1.2.3.4/123");
    finish_phase();
  endtask

  task automatic test_format_errors();
    send_string("1.2.3.4");
    send_string("1.2.3.4/");
    send_string("1.2.3./8");
    send_string(".1.2.3/4");
    send_string("1..3.4/5");
    send_string("1.2.3.4.5/6");
    send_string("1.2/3");
    send_string("1.2.3.4/5.6");
    send_string("1.2.3.4/5/6");
    send_string("a.2.3.4/5");
    send_string("");
    finish_phase();
  endtask

  // over-long strings, bytes above 0x7F, and an error held to the end
  task automatic test_long_and_binary();
    send_string("123.123.123.123/3299999999999");
    send_string("1.2.3.4/51234567890123456789012345678901234");
    send_string("x1.2.3.4/5");
    text_buf.delete();
    append_text("1.2.3.4/5");
    text_buf[1] = 8'h80;
    send_text_buf();
    text_buf.delete();
    append_text("1.2.3.4/5");
    text_buf[8] = 8'hFF;
    send_text_buf();
    send_string("10.20.30.40/24");
    finish_phase();
  endtask

  // receiver holds off while the sender keeps pushing short strings
  task automatic test_output_backpressure();
    max_src_gap = 0;
    max_snk_gap = 0;
    hold_off_cycles = 150;
    repeat (12) begin
      build_address();
      send_text_buf();
    end
    finish_phase();
  endtask

  task automatic test_random_strings();
    int start;
    int phase;
    start = chars_parsed;
    while (chars_parsed - start < RANDOM_CHARS_TARGET) begin
      phase = ((chars_parsed - start) / PHASE_CHARS) % 4;
      case (phase)
        0: begin max_src_gap = 18; max_snk_gap = 18; end
        1: begin max_src_gap = 0;  max_snk_gap = 0;  end
        2: begin max_src_gap = 0;  max_snk_gap = 18; end
        default: begin max_src_gap = 18; max_snk_gap = 0; end
      endcase
      if ($urandom_range(7, 0) == 0) begin
        text_buf.delete();
        repeat ($urandom_range(26, 0)) text_buf.push_back(8'($urandom_range(255, 1)));
      end else begin
        build_address();
      end
      send_text_buf();
    end
    finish_phase();
  endtask

  initial begin : verdict_sink
    int gap;
    out_chan.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_chan.ready <= 1'b0;
        while (hold_off_cycles > 0) begin
          @(posedge clk);
          hold_off_cycles--;
        end
      end
      gap = $urandom_range(max_snk_gap, 0);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      check_verdict(out_chan.valid_res);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $time, idle_cycles);
      $display("** ipv4_cidr_string_validator: FAILED **");
      $finish;
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.ch    = CH_NUL;
    clear_tracker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    max_src_gap = 3;
    max_snk_gap = 3;
    test_well_formed();
    test_field_limits();
    test_format_errors();
    test_long_and_binary();
    test_output_backpressure();
    test_random_strings();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("** ipv4_cidr_string_validator: PASSED **");
    end else begin
      $display("** ipv4_cidr_string_validator: FAILED **");
    end
    $finish;
  end

endmodule
